FILE: src/tfas_pkg.sv
// ----------------------------------------------------------------------------
// tfas_pkg: shared types and constants of the triangle fan angle sum
// Fixed formats, the arctangent table, controller states and the
// command / status words between controller and datapath.
// ----------------------------------------------------------------------------
package tfas_pkg;

    // Port and internal widths
    localparam int IN_W        = 32;   // coordinate field on the input word
    localparam int COORD_MAX_W = 48;   // widest coordinate the design supports
    localparam int MUL_W       = 31;   // shrunk edge component, |v| <= 2^29
    localparam int PROD_W      = 62;   // one edge product
    localparam int XY_W        = 64;   // cross, dot and CORDIC vector
    localparam int ANG_W       = 28;   // angle in radians, Q4.24 signed
    localparam int Q16_W       = 19;   // rounded angle, Q3.16 unsigned
    localparam int SUM_W       = 24;   // angle sum, Q8.16 unsigned
    localparam int STEP_W      = 5;    // CORDIC step index, up to 32 steps
    localparam int MUL_OPS     = 4;    // products per triangle

    localparam int EDGE_LIMIT  = 536870912;  // 2^29
    localparam int ANG_FRAC    = 24;
    localparam int TABLE_HEAD  = 9;
    localparam int ROUND_BIAS  = 128;
    localparam int ROUND_SHIFT = 8;

    localparam logic signed [ANG_W-1:0] HALF_PI = 28'sd26353589;

    // atan(2^-i) * 2^24 for the first steps; beyond them it is 2^(24-i), and 0 past i = 24
    localparam logic signed [ANG_W-1:0] ATAN_HEAD [TABLE_HEAD] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
        28'sd524117,   28'sd262123,  28'sd131069,  28'sd65536
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHRINK,
        S_MUL,
        S_PREP,
        S_ROT,
        S_DONE
    } t_state;

    // Edge products in the order the multiplier takes them
    typedef enum logic [1:0] {
        P_E1X_E2Y,
        P_E2X_E1Y,
        P_E1X_E2X,
        P_E1Y_E2Y
    } t_prod;

    typedef struct packed {
        logic              load;     // capture a new triangle
        logic              shrink;   // halve oversized edges
        logic              mul_en;   // register one product
        t_prod             mul_sel;
        logic              acc_en;   // fold the last product into cross/dot
        t_prod             acc_sel;
        logic              prep;     // set up the CORDIC vector
        logic              rot;      // one CORDIC step
        logic [STEP_W-1:0] step;
        logic              accum;    // add the angle into the sum
        logic              emit;     // load the result word and clear the sum
    } t_cmd;

    typedef struct packed {
        logic shrink_busy;
        logic last;
    } t_stat;

    function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        if (i < STEP_W'(TABLE_HEAD)) begin
            r = ATAN_HEAD[i[3:0]];
        end else if (i <= STEP_W'(ANG_FRAC)) begin
            r = ANG_W'(1) << (STEP_W'(ANG_FRAC) - i);
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

FILE: src/tfas_if.sv
// ----------------------------------------------------------------------------
// tfas_if: valid/ready channels of the triangle fan angle sum
// One triangle word in, one angle sum word out.
// ----------------------------------------------------------------------------
interface tfas_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tfas_pkg::IN_W-1:0]    apex_x;
    logic signed [tfas_pkg::IN_W-1:0]    apex_y;
    logic signed [tfas_pkg::IN_W-1:0]    first_x;
    logic signed [tfas_pkg::IN_W-1:0]    first_y;
    logic signed [tfas_pkg::IN_W-1:0]    second_x;
    logic signed [tfas_pkg::IN_W-1:0]    second_y;
    logic                                last_slice;

    modport source (
        output valid, apex_x, apex_y, first_x, first_y, second_x, second_y, last_slice,
        input  ready
    );
    modport sink (
        input  valid, apex_x, apex_y, first_x, first_y, second_x, second_y, last_slice,
        output ready
    );
endinterface

interface tfas_out_if;
    logic                           valid;
    logic                           ready;
    logic [tfas_pkg::SUM_W-1:0]     total_angle;
    logic                           saturated;

    modport source (
        output valid, total_angle, saturated,
        input  ready
    );
    modport sink (
        input  valid, total_angle, saturated,
        output ready
    );
endinterface

FILE: src/tfas_ctrl.sv
// ----------------------------------------------------------------------------
// tfas_ctrl: sequencer of the triangle fan angle sum
// Walks each triangle through edge shrink, products, CORDIC steps and the
// accumulate step; owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module tfas_ctrl #(
    parameter int CORDIC_ITERATIONS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tfas_pkg::t_cmd   o_cmd,
    input  tfas_pkg::t_stat  i_stat
);

    localparam int IDX_W = $clog2(CORDIC_ITERATIONS);

    tfas_pkg::t_state r_state, n_state;
    logic [2:0]       r_mcnt, n_mcnt;
    logic [IDX_W-1:0] r_icnt, n_icnt;
    logic             r_out_valid, n_out_valid;

    // State, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfas_pkg::S_IDLE;
            r_mcnt      <= '0;
            r_icnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mcnt      <= n_mcnt;
            r_icnt      <= n_icnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_mcnt      = r_mcnt;
        n_icnt      = r_icnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            tfas_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tfas_pkg::S_SHRINK;
                end
            end
            tfas_pkg::S_SHRINK: begin
                n_mcnt = '0;
                if (i_stat.shrink_busy) begin
                    o_cmd.shrink = 1'b1;
                end else begin
                    n_state = tfas_pkg::S_MUL;
                end
            end
            tfas_pkg::S_MUL: begin
                // issue a product while folding in the one before it
                o_cmd.mul_en  = (r_mcnt < 3'(tfas_pkg::MUL_OPS));
                o_cmd.mul_sel = tfas_pkg::t_prod'(r_mcnt[1:0]);
                o_cmd.acc_en  = (r_mcnt != 3'd0);
                o_cmd.acc_sel = tfas_pkg::t_prod'(2'(r_mcnt - 3'd1));
                n_mcnt        = r_mcnt + 3'd1;
                if (r_mcnt == 3'(tfas_pkg::MUL_OPS)) begin
                    n_state = tfas_pkg::S_PREP;
                end
            end
            tfas_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_icnt     = '0;
                n_state    = tfas_pkg::S_ROT;
            end
            tfas_pkg::S_ROT: begin
                o_cmd.rot  = 1'b1;
                o_cmd.step = tfas_pkg::STEP_W'(r_icnt);
                if (r_icnt == IDX_W'(CORDIC_ITERATIONS - 1)) begin
                    n_state = tfas_pkg::S_DONE;
                end else begin
                    n_icnt = r_icnt + IDX_W'(1);
                end
            end
            tfas_pkg::S_DONE: begin
                // hold a last triangle while the previous word is still waiting
                if (!(i_stat.last && r_out_valid && !i_out_ready)) begin
                    o_cmd.accum = 1'b1;
                    o_cmd.emit  = i_stat.last;
                    if (i_stat.last) begin
                        n_out_valid = 1'b1;
                    end
                    n_state = tfas_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tfas_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: src/tfas_dp.sv
// ----------------------------------------------------------------------------
// tfas_dp: datapath of the triangle fan angle sum
// Edge registers, one shared multiplier for cross and dot, a vectoring
// CORDIC stepped once per cycle, and the saturating Q8.16 accumulator.
// ----------------------------------------------------------------------------
module tfas_dp #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tfas_pkg::t_cmd                      i_cmd,
    output tfas_pkg::t_stat                     o_stat,
    input  logic signed [tfas_pkg::IN_W-1:0]    i_apex_x,
    input  logic signed [tfas_pkg::IN_W-1:0]    i_apex_y,
    input  logic signed [tfas_pkg::IN_W-1:0]    i_first_x,
    input  logic signed [tfas_pkg::IN_W-1:0]    i_first_y,
    input  logic signed [tfas_pkg::IN_W-1:0]    i_second_x,
    input  logic signed [tfas_pkg::IN_W-1:0]    i_second_y,
    input  logic                                i_last_slice,
    output logic [tfas_pkg::SUM_W-1:0]          o_total_angle,
    output logic                                o_saturated
);

    localparam int EW = (COORD_WIDTH + 1 > tfas_pkg::MUL_W) ? COORD_WIDTH + 1
                                                            : tfas_pkg::MUL_W;
    localparam int XY_W  = tfas_pkg::XY_W;
    localparam int ANG_W = tfas_pkg::ANG_W;
    localparam int SUM_W = tfas_pkg::SUM_W;

    localparam logic signed [EW-1:0] EDGE_LIM   = EW'(tfas_pkg::EDGE_LIMIT);
    localparam logic signed [EW-1:0] EDGE_LIM_N = -EDGE_LIM;

    // Low COORD_WIDTH bits of a field, taken as two's complement
    function automatic logic signed [EW-1:0] coord(input logic [tfas_pkg::IN_W-1:0] raw);
        logic [tfas_pkg::COORD_MAX_W-1:0] wide;
        logic [COORD_WIDTH-1:0]           c;
        wide = tfas_pkg::COORD_MAX_W'(raw);
        c    = wide[COORD_WIDTH-1:0];
        return EW'(signed'(c));
    endfunction

    // Halve with truncation toward zero
    function automatic logic signed [EW-1:0] half(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] t;
        t = signed'(v + EW'(v[EW-1]));
        return t >>> 1;
    endfunction

    function automatic logic too_big(input logic signed [EW-1:0] v);
        return (v > EDGE_LIM) || (v < EDGE_LIM_N);
    endfunction

    logic signed [EW-1:0]                   r_e1x, r_e1y, r_e2x, r_e2y;
    logic                                   r_last;
    logic signed [tfas_pkg::PROD_W-1:0]     r_prod;
    logic signed [XY_W-1:0]                 r_cross, r_dot;
    logic signed [XY_W-1:0]                 r_x, r_y;
    logic signed [ANG_W-1:0]                r_z;
    logic                                   r_zero;
    logic [SUM_W-1:0]                       r_sum;
    logic                                   r_clamped;
    logic [SUM_W-1:0]                       r_total;
    logic                                   r_sat;

    logic                                   need1, need2;
    logic signed [tfas_pkg::MUL_W-1:0]      mul_a, mul_b;
    logic signed [tfas_pkg::PROD_W-1:0]     prod;
    logic signed [XY_W-1:0]                 prod_ext, cross_abs, dx, dy;
    logic signed [ANG_W-1:0]                step_ang, ang;
    logic [ANG_W-1:0]                       ang_pos, ang_rnd;
    logic [tfas_pkg::Q16_W-1:0]             q16;
    logic [SUM_W:0]                         sum_wide;
    logic [SUM_W-1:0]                       sum_sat;
    logic                                   clamp_next;

    // Edge shrink status
    assign need1  = too_big(r_e1x) || too_big(r_e1y);
    assign need2  = too_big(r_e2x) || too_big(r_e2y);
    assign o_stat = '{shrink_busy: need1 || need2, last: r_last};

    // Select the operands of the shared multiplier
    always_comb begin
        unique case (i_cmd.mul_sel)
            tfas_pkg::P_E1X_E2Y: begin
                mul_a = r_e1x[tfas_pkg::MUL_W-1:0];
                mul_b = r_e2y[tfas_pkg::MUL_W-1:0];
            end
            tfas_pkg::P_E2X_E1Y: begin
                mul_a = r_e2x[tfas_pkg::MUL_W-1:0];
                mul_b = r_e1y[tfas_pkg::MUL_W-1:0];
            end
            tfas_pkg::P_E1X_E2X: begin
                mul_a = r_e1x[tfas_pkg::MUL_W-1:0];
                mul_b = r_e2x[tfas_pkg::MUL_W-1:0];
            end
            tfas_pkg::P_E1Y_E2Y: begin
                mul_a = r_e1y[tfas_pkg::MUL_W-1:0];
                mul_b = r_e2y[tfas_pkg::MUL_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod      = mul_a * mul_b;
    assign prod_ext  = XY_W'(r_prod);
    assign cross_abs = r_cross[XY_W-1] ? -r_cross : r_cross;

    // CORDIC step terms
    assign dx       = r_y >>> i_cmd.step;
    assign dy       = r_x >>> i_cmd.step;
    assign step_ang = tfas_pkg::atan_step(i_cmd.step);

    // Clamp, round to Q8.16 and add into the saturating sum
    assign ang        = r_zero ? tfas_pkg::HALF_PI : r_z;
    assign ang_pos    = ang[ANG_W-1] ? '0 : ang;
    assign ang_rnd    = ang_pos + ANG_W'(tfas_pkg::ROUND_BIAS);
    assign q16        = ang_rnd[tfas_pkg::ROUND_SHIFT +: tfas_pkg::Q16_W];
    assign sum_wide   = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(q16);
    assign sum_sat    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    assign clamp_next = r_clamped | sum_wide[SUM_W];

    // Edges, products and CORDIC vector
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_e1x  <= coord(i_first_x) - coord(i_apex_x);
            r_e1y  <= coord(i_first_y) - coord(i_apex_y);
            r_e2x  <= coord(i_second_x) - coord(i_apex_x);
            r_e2y  <= coord(i_second_y) - coord(i_apex_y);
            r_last <= i_last_slice;
        end
        if (i_cmd.shrink) begin
            if (need1) begin
                r_e1x <= half(r_e1x);
                r_e1y <= half(r_e1y);
            end
            if (need2) begin
                r_e2x <= half(r_e2x);
                r_e2y <= half(r_e2y);
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
        end
        if (i_cmd.acc_en) begin
            unique case (i_cmd.acc_sel)
                tfas_pkg::P_E1X_E2Y: r_cross <= prod_ext;
                tfas_pkg::P_E2X_E1Y: r_cross <= r_cross - prod_ext;
                tfas_pkg::P_E1X_E2X: r_dot   <= prod_ext;
                tfas_pkg::P_E1Y_E2Y: r_dot   <= r_dot + prod_ext;
                default:             r_dot   <= r_dot;
            endcase
        end
        if (i_cmd.prep) begin
            // turn an obtuse vector by -pi/2 first
            r_zero <= (r_cross == '0) && (r_dot == '0);
            if (r_dot[XY_W-1]) begin
                r_x <= cross_abs;
                r_y <= -r_dot;
                r_z <= tfas_pkg::HALF_PI;
            end else begin
                r_x <= r_dot;
                r_y <= cross_abs;
                r_z <= '0;
            end
        end
        if (i_cmd.rot) begin
            // rotate toward the x axis on the sign of y
            if (!r_y[XY_W-1]) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + step_ang;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - step_ang;
            end
        end
        if (i_cmd.emit) begin
            r_total <= sum_sat;
            r_sat   <= clamp_next;
        end
    end

    // Running sum and its clamp flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_clamped <= 1'b0;
        end else if (i_cmd.accum) begin
            if (i_cmd.emit) begin
                r_sum     <= '0;
                r_clamped <= 1'b0;
            end else begin
                r_sum     <= sum_sat;
                r_clamped <= clamp_next;
            end
        end
    end

    assign o_total_angle = r_total;
    assign o_saturated   = r_sat;

endmodule

FILE: src/triangle_fan_angle_sum.sv
// ----------------------------------------------------------------------------
// triangle_fan_angle_sum: apex angle sum of a triangle fan
// Each input word is one triangle; its apex angle atan2(|cross|, dot) comes
// from a vectoring CORDIC and adds into a saturating Q8.16 radian sum that
// is emitted and cleared on the triangle flagged last.
//
//   channel  dir  payload                                    last word
//   i_in     in   apex/first/second x,y Q16.16, last_slice   last_slice
//   o_out    out  total_angle Q8.16, saturated               one per fan
//
// From accept to the next ready a triangle runs through the halvings an
// edge needs to fit 2^29 (0 to 3 for 32-bit coordinates), the products
// and the CORDIC steps; the one-step-per-cycle CORDIC takes most of it.
// Products come from one 31x31 multiplier, four products per triangle.
// Reset clears the sum, the controller and the output valid at once.
// A finished word waits in the output register while the next triangle
// runs; only a last triangle stalls, at its accumulate step, until then.
// ----------------------------------------------------------------------------
module triangle_fan_angle_sum #(
    parameter int CORDIC_ITERATIONS = 20,
    parameter int COORD_WIDTH       = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tfas_in_if.sink      i_in,
    tfas_out_if.source   o_out
);

    tfas_pkg::t_cmd  cmd;
    tfas_pkg::t_stat stat;

    // Sequencer
    tfas_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Arithmetic
    tfas_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_apex_x      (i_in.apex_x),
        .i_apex_y      (i_in.apex_y),
        .i_first_x     (i_in.first_x),
        .i_first_y     (i_in.first_y),
        .i_second_x    (i_in.second_x),
        .i_second_y    (i_in.second_y),
        .i_last_slice  (i_in.last_slice),
        .o_total_angle (o_out.total_angle),
        .o_saturated   (o_out.saturated)
    );

    // One triangle at a time: no word is taken right after another
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a triangle is in work");

    // A result word appears only at the end of a triangle's work
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result word without a finished triangle");

    // A clamped sum stays pinned at its maximum
    a_sat_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |-> (o_out.total_angle == '1))
        else $error("saturated word below the maximum sum");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for triangle_fan_angle_sum
// Feeds fans of triangles through the valid/ready input channel and
// predicts every fan's apex angle sum with a bit-exact integer model:
// edge shrinking, exact cross and dot products, vectoring CORDIC,
// Q8.16 rounding and the saturating sum. Each output word is compared
// with the oldest predicted fan sum. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CORDIC_STEPS = 20;
    localparam int     COORD_BITS   = 32;
    localparam int     RANDOM_ITEMS = 500;
    localparam longint HALF_PI_Q24  = 64'sd26353589;
    localparam longint EDGE_CAP     = 64'sd536870912;
    localparam longint SUM_CEIL     = 64'sd16777215;
    localparam int     CALM_FIRST   = 3000;
    localparam int     CALM_LAST    = 6000;
    localparam int     DRAIN_CYCLES = 80;

    typedef logic signed [tfas_pkg::IN_W-1:0] coord_t;

    typedef struct {
        coord_t apex_x;
        coord_t apex_y;
        coord_t first_x;
        coord_t first_y;
        coord_t second_x;
        coord_t second_y;
        logic   last_slice;
    } triangle_t;

    typedef struct {
        logic [tfas_pkg::SUM_W-1:0] total_angle;
        logic                       saturated;
    } fan_sum_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tfas_in_if  tri_bus ();
    tfas_out_if sum_bus ();

    triangle_t                  pending_tris [$];
    triangle_t                  tri_on_bus;
    fan_sum_t                   sums_due [$];
    logic [tfas_pkg::SUM_W-1:0] fan_sum       = '0;
    logic                       fan_clamped   = 1'b0;
    int                         mismatch_count = 0;
    int                         cycle_no       = 0;
    int                         stall_left     = 0;

    triangle_fan_angle_sum #(
        .CORDIC_ITERATIONS (CORDIC_STEPS),
        .COORD_WIDTH       (COORD_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tri_bus),
        .o_out   (sum_bus)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    // ------------------------------------------------------------------
    // Angle sum prediction
    // ------------------------------------------------------------------
    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint half_toward_zero(longint v);
        return (v < 0) ? -((-v) >>> 1) : (v >>> 1);
    endfunction

    // atan(2^-i) in radians scaled by 2^24
    function automatic longint atan_q24(int i);
        longint r;
        case (i)
            0:       r = 13176795;
            1:       r = 7778716;
            2:       r = 4110060;
            3:       r = 2086331;
            4:       r = 1047214;
            5:       r = 524117;
            6:       r = 262123;
            7:       r = 131069;
            8:       r = 65536;
            default: r = (i <= 24) ? (64'sd1 <<< (24 - i)) : 64'sd0;
        endcase
        return r;
    endfunction

    // Apex angle atan2(|cross|, dot), radians scaled by 2^24, clamped at 0
    function automatic longint apex_angle_q24(triangle_t t);
        longint e1x, e1y, e2x, e2y;
        longint vx, vy, z, dx, dy, swap;
        int     i;
        e1x = longint'(t.first_x) - longint'(t.apex_x);
        e1y = longint'(t.first_y) - longint'(t.apex_y);
        e2x = longint'(t.second_x) - longint'(t.apex_x);
        e2y = longint'(t.second_y) - longint'(t.apex_y);

        // shrink each edge on its own so the products stay exact
        while (mag(e1x) > EDGE_CAP || mag(e1y) > EDGE_CAP) begin
            e1x = half_toward_zero(e1x);
            e1y = half_toward_zero(e1y);
        end
        while (mag(e2x) > EDGE_CAP || mag(e2y) > EDGE_CAP) begin
            e2x = half_toward_zero(e2x);
            e2y = half_toward_zero(e2y);
        end
        vy = mag(e1x * e2y - e2x * e1y);
        vx = e1x * e2x + e1y * e2y;

        // zero-length edge gives a right angle
        if (vx == 0 && vy == 0) begin
            return HALF_PI_Q24;
        end

        // obtuse: turn by -pi/2 first
        z = 0;
        if (vx < 0) begin
            swap = vy;
            vy   = -vx;
            vx   = swap;
            z    = HALF_PI_Q24;
        end
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx = vx + dx;
                vy = vy - dy;
                z  = z + atan_q24(i);
            end else begin
                vx = vx - dx;
                vy = vy + dy;
                z  = z - atan_q24(i);
            end
        end
        return (z < 0) ? 64'sd0 : z;
    endfunction

    // Add one triangle into the fan sum; queue the sum on the last one
    function automatic void fold_triangle(triangle_t t);
        longint   q16;
        longint   next_sum;
        fan_sum_t done;
        q16      = (apex_angle_q24(t) + 128) >>> 8;
        next_sum = longint'(fan_sum) + q16;
        if (next_sum > SUM_CEIL) begin
            next_sum    = SUM_CEIL;
            fan_clamped = 1'b1;
        end
        fan_sum = tfas_pkg::SUM_W'(next_sum);
        if (t.last_slice) begin
            done.total_angle = fan_sum;
            done.saturated   = fan_clamped;
            sums_due.push_back(done);
            fan_sum     = '0;
            fan_clamped = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic triangle_t make_tri(coord_t ax, coord_t ay, coord_t fx, coord_t fy,
                                           coord_t sx, coord_t sy, logic last);
        triangle_t t;
        t.apex_x     = ax;
        t.apex_y     = ay;
        t.first_x    = fx;
        t.first_y    = fy;
        t.second_x   = sx;
        t.second_y   = sy;
        t.last_slice = last;
        return t;
    endfunction

    // Edge component of random magnitude, from a few units to full range
    function automatic coord_t rand_edge();
        coord_t v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic triangle_t random_tri(bit near_pi_only, logic last);
        coord_t ax, ay, e1x, e1y, e2x, e2y;
        int     kind;
        ax   = $urandom;
        ay   = $urandom;
        e1x  = rand_edge();
        e1y  = rand_edge();
        e2x  = rand_edge();
        e2y  = rand_edge();
        kind = near_pi_only ? 99 : $urandom_range(0, 99);
        if (kind < 20) begin
            // arbitrary corners over the whole range
            return make_tri(ax, ay, $urandom, $urandom, $urandom, $urandom, last);
        end else if (kind >= 75 && kind < 87) begin
            // degenerate: zero edges or collinear edges
            case ($urandom_range(0, 3))
                0: begin e1x = '0; e1y = '0; end
                1: begin e2x = '0; e2y = '0; end
                2: begin e1x = '0; e1y = '0; e2x = '0; e2y = '0; end
                default: begin e2x = e1x <<< 1; e2y = e1y <<< 1; end
            endcase
        end else if (kind >= 87) begin
            // nearly opposite edges, angle close to pi
            e2x = -e1x + coord_t'(int'($urandom_range(0, 6)) - 3);
            e2y = -e1y + coord_t'(int'($urandom_range(0, 6)) - 3);
        end
        return make_tri(ax, ay, ax + e1x, ay + e1y, ax + e2x, ay + e2y, last);
    endfunction

    function automatic bit calm_stretch();
        return cycle_no >= CALM_FIRST && cycle_no < CALM_LAST;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued triangle words, hold each until accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tri_bus.valid <= 1'b0;
        end else begin
            if (tri_bus.valid && tri_bus.ready) begin
                fold_triangle(tri_on_bus);
            end
            if (!tri_bus.valid || tri_bus.ready) begin
                if (pending_tris.size() != 0
                        && (calm_stretch() || $urandom_range(0, 99) >= 13)) begin
                    tri_on_bus = pending_tris.pop_front();
                    tri_bus.valid      <= 1'b1;
                    tri_bus.apex_x     <= tri_on_bus.apex_x;
                    tri_bus.apex_y     <= tri_on_bus.apex_y;
                    tri_bus.first_x    <= tri_on_bus.first_x;
                    tri_bus.first_y    <= tri_on_bus.first_y;
                    tri_bus.second_x   <= tri_on_bus.second_x;
                    tri_bus.second_y   <= tri_on_bus.second_y;
                    tri_bus.last_slice <= tri_on_bus.last_slice;
                end else begin
                    tri_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each sum word, stall the output at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        fan_sum_t want;
        int       roll;
        if (!i_rst_n) begin
            sum_bus.ready <= 1'b0;
        end else begin
            if (sum_bus.valid && sum_bus.ready) begin
                if (sums_due.size() == 0) begin
                    $error("total_angle: expected no word, actual %0d saturated %0b",
                           sum_bus.total_angle, sum_bus.saturated);
                    mismatch_count++;
                end else begin
                    want = sums_due.pop_front();
                    if (sum_bus.total_angle !== want.total_angle) begin
                        $error("total_angle: expected %0d, actual %0d",
                               want.total_angle, sum_bus.total_angle);
                        mismatch_count++;
                    end
                    if (sum_bus.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, sum_bus.saturated);
                        mismatch_count++;
                    end
                end
            end

            // mostly short stalls, now and then a long one
            roll = $urandom_range(0, 999);
            if (stall_left > 0) begin
                stall_left--;
                sum_bus.ready <= 1'b0;
            end else if (calm_stretch()) begin
                sum_bus.ready <= 1'b1;
            end else if (roll < 1) begin
                stall_left = $urandom_range(20, 60);
                sum_bus.ready <= 1'b0;
            end else if (roll < 100) begin
                sum_bus.ready <= 1'b0;
            end else begin
                sum_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int rand_items;
        int fan_len;
        int fan_no;
        int k;
        bit long_fan;

        i_rst_n            = 1'b0;
        tri_bus.valid      = 1'b0;
        tri_bus.apex_x     = '0;
        tri_bus.apex_y     = '0;
        tri_bus.first_x    = '0;
        tri_bus.first_y    = '0;
        tri_bus.second_x   = '0;
        tri_bus.second_y   = '0;
        tri_bus.last_slice = 1'b0;
        sum_bus.ready      = 1'b0;

        // Directed: zero-length edges, right, acute, obtuse, straight, zero angle
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 1'b1));
        pending_tris.push_back(make_tri(0, 0, 32'sh10000, 0, 0, 32'sh10000, 1'b0));
        pending_tris.push_back(make_tri(0, 0, 32'sh10000, 0, 32'sh10000, 32'sh10000, 1'b0));
        pending_tris.push_back(make_tri(0, 0, 32'sh10000, 0, -32'sh10000, 32'sh10000, 1'b0));
        pending_tris.push_back(make_tri(0, 0, 32'sh10000, 0, -32'sh10000, 0, 1'b0));
        pending_tris.push_back(make_tri(7, 9, 37, 49, 37, 49, 1'b1));
        // one edge of zero length
        pending_tris.push_back(make_tri(-5, 7, -5, 7, 32'sh123456, -32'sh4321, 1'b0));
        pending_tris.push_back(make_tri(-5, 7, 32'sh7654, 32'sh3, -5, 7, 1'b0));
        // coordinate extremes, edges that need the most halving
        pending_tris.push_back(make_tri(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                                        32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b0));
        pending_tris.push_back(make_tri(32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                                        32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0));
        pending_tris.push_back(make_tri(-1, -1, -1, -1, -1, -1, 1'b0));
        pending_tris.push_back(make_tri(100, 100, 101, 100, 100, 101, 1'b0));
        pending_tris.push_back(make_tri(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1));
        pending_tris.push_back(make_tri(0, 0, 32'sh7fffffff, 32'sh7fffffff,
                                        32'sh80000000, 32'sh80000000, 1'b0));
        pending_tris.push_back(make_tri(0, 0, 32'sh7fffffff, 0, 0, 32'sh80000000, 1'b1));
        // tiny, near-straight and obtuse angles
        pending_tris.push_back(make_tri(0, 0, 32'sh40000000, 0, 32'sh40000000, 1, 1'b1));
        pending_tris.push_back(make_tri(0, 0, 32'sh100000, 1, -32'sh100000, 0, 1'b1));
        pending_tris.push_back(make_tri(0, 0, 0, 32'sh10000, -32'sh10000, -32'sh10000, 1'b1));

        // Random fans; long fans of near-straight angles can drive the sum to its clamp
        rand_items = 0;
        fan_no     = 0;
        while (rand_items < RANDOM_ITEMS) begin
            long_fan = (fan_no == 10) || ($urandom_range(0, 99) < 3);
            fan_len  = long_fan ? $urandom_range(78, 110) : $urandom_range(1, 6);
            for (k = 0; k < fan_len; k++) begin
                pending_tris.push_back(random_tri(long_fan && $urandom_range(0, 19) != 0,
                                                  k == fan_len - 1));
            end
            rand_items += fan_len;
            fan_no++;
        end

        // Release reset once the stimulus is queued
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all words accepted, all sums seen, then a quiet tail
        while (pending_tris.size() != 0 || tri_bus.valid) @(posedge i_clk);
        while (sums_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
src/tfas_pkg.sv
src/tfas_if.sv
src/tfas_ctrl.sv
src/tfas_dp.sv
src/triangle_fan_angle_sum.sv
tb/tb.sv
